// ----- rtl/core/lbrs_pkg.sv -----
`default_nettype none
package lbrs_pkg;
   localparam int IN_FRAC_BITS  = 16;
   localparam int OUT_FRAC_BITS = 24;
   localparam int OP_W   = 32;
   localparam int OUT_W  = 40;
   localparam int WORK_W = 48;
   localparam int STEP_W = OUT_FRAC_BITS + 1;
   localparam int CNT_W  = 6;
   localparam logic [OP_W-1:0] BASE_RESET = 32'd178145;
   localparam logic [WORK_W-1:0] ONE_W = WORK_W'(1) << IN_FRAC_BITS;
   localparam logic [0:0] REG_LOG_BASE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RECIP, ST_CHECK, ST_DIV, ST_SQRT, ST_DONE
   } state_type;

   typedef struct packed {
      logic [OUT_W-1:0] log_value;
      logic             saturated;
      logic             domain_error;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/core/lbrs_if.sv -----
`default_nettype none
interface lbrs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] operand;
   modport source (output valid, output operand, input ready);
   modport sink (input valid, input operand, output ready);
endinterface

interface lbrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [39:0] log_value;
   logic        saturated;
   logic        domain_error;
   modport source (output valid, output log_value, output saturated, output domain_error,
      input ready);
   modport sink (input valid, input log_value, input saturated, input domain_error,
      output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lbrs_divsqrt.sv -----
`default_nettype none
// Shared radix-2 restoring unit: division (one quotient bit a cycle) or
// integer square root (one root bit a cycle).
module lbrs_divsqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      is_sqrt,
   input  wire logic [lbrs_pkg::WORK_W-1:0] num,
   input  wire logic [lbrs_pkg::WORK_W-1:0] den,
   output logic                           done,
   output logic [lbrs_pkg::WORK_W-1:0]    result
);
   import lbrs_pkg::*;
   localparam int N_W = 2 * WORK_W;

   logic [N_W-1:0]    num_ff, num_in;
   logic [WORK_W+1:0] rem_ff, rem_in;
   logic [WORK_W-1:0] quo_ff, quo_in, den_ff, den_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, sq_ff, sq_in;
   logic [WORK_W+1:0] trial, diff;
   logic [WORK_W+1:0] shifted;

   // one step of the recurrence
   always_comb begin
      if (sq_ff) begin
         shifted = {rem_ff[WORK_W-1:0], num_ff[N_W-1 -: 2]};
         trial   = {quo_ff, 2'b01};
      end else begin
         shifted = {rem_ff[WORK_W:0], num_ff[N_W-1]};
         trial   = {2'b00, den_ff};
      end
      diff = shifted - trial;
   end

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; sq_in = sq_ff;
      if (start) begin
         busy_in = 1'b1; sq_in = is_sqrt; rem_in = '0; quo_in = '0; den_in = den;
         // division: numerator num<<FRAC; sqrt: radicand num<<FRAC, 2 bits a step
         num_in = {num, {WORK_W{1'b0}}} >> (WORK_W - IN_FRAC_BITS);
         cnt_in = is_sqrt ? 7'(N_W / 2) : 7'(N_W);
      end else if (busy_ff) begin
         num_in = sq_ff ? {num_ff[N_W-3:0], 2'b00} : {num_ff[N_W-2:0], 1'b0};
         if (shifted >= trial) begin
            rem_in = diff; quo_in = {quo_ff[WORK_W-2:0], 1'b1};
         end else begin
            rem_in = shifted; quo_in = {quo_ff[WORK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; sq_ff <= sq_in;
   end

   assign done   = busy_ff && (cnt_ff == 7'd1) && !start;
   assign result = quo_in;
endmodule
`default_nettype wire

// ----- rtl/core/log_by_repeated_square_root_core.sv -----
`default_nettype none
// Run time depends on the data. Each division and each square root is a check state
// followed by a bit-serial run on the one shared unit; a reciprocal adds a division
// run. Worst case is the smallest base, where up to 32768 divisions run before the
// result saturates. One item at a time.
// Result register lets the next operand enter while a result waits.
// Reset (synchronous, active high) clears control and sets log_base to e.
module log_by_repeated_square_root_core (
   input  wire logic clock,
   input  wire logic reset,
   lbrs_req_if.sink  req,
   lbrs_rsp_if.source rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lbrs_pkg::*;

   state_type st_ff, st_in;
   logic [OP_W-1:0]   base_ff, base_in;
   logic [WORK_W-1:0] w_ff, w_in, s_ff, s_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [OUT_W-1:0]  mag_ff, mag_in;
   logic neg_ff, neg_in, sat_ff, sat_in, dom_ff, dom_in;
   rsp_type out_ff, out_in;
   logic ov_ff, ov_in;
   logic du_start, du_sqrt, du_done;
   logic [WORK_W-1:0] du_num, du_den, du_res;
   logic [OUT_W-1:0] lim, mag_sum;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LOG_BASE) ? base_ff : 32'd0;
   assign base_in = (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_LOG_BASE)
                    ? csr_pwdata : base_ff;

   lbrs_divsqrt u_du (.clock, .reset, .start(du_start), .is_sqrt(du_sqrt),
      .num(du_num), .den(du_den), .done(du_done), .result(du_res));

   assign lim     = neg_ff ? (OUT_W'(1) << (OUT_W-1)) : ((OUT_W'(1) << (OUT_W-1)) - OUT_W'(1));
   assign mag_sum = mag_ff + OUT_W'(step_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (req.valid) st_in = (req.operand == '0) ? ST_DONE :
                     (WORK_W'(req.operand) < ONE_W) ? ST_RECIP : ST_CHECK;
         ST_RECIP: if (du_done) st_in = ST_CHECK;
         ST_CHECK: begin
            if (w_ff == ONE_W || s_ff <= ONE_W || step_ff == '0) st_in = ST_DONE;
            else if (w_ff >= s_ff) st_in = (mag_sum > lim) ? ST_DONE : ST_DIV;
            else st_in = ST_SQRT;
         end
         ST_DIV, ST_SQRT: if (du_done) st_in = ST_CHECK;
         ST_DONE: if (!ov_ff || rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      w_in = w_ff; s_in = s_ff; step_in = step_ff; mag_in = mag_ff;
      neg_in = neg_ff; sat_in = sat_ff; dom_in = dom_ff;
      out_in = out_ff; ov_in = ov_ff;
      du_start = 1'b0; du_sqrt = 1'b0; du_num = w_ff; du_den = s_ff;
      req.ready = 1'b0;
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            w_in = WORK_W'(req.operand); s_in = WORK_W'(base_ff);
            step_in = STEP_W'(1) << OUT_FRAC_BITS; mag_in = '0; sat_in = 1'b0;
            dom_in = (req.operand == '0);
            neg_in = (req.operand != '0) && (WORK_W'(req.operand) < ONE_W);
            if (req.valid && neg_in) begin
               // 2^(2F)/x = (2^F << F)/x
               du_start = 1'b1; du_num = ONE_W; du_den = WORK_W'(req.operand);
            end
         end
         ST_RECIP: if (du_done) w_in = du_res;
         ST_CHECK: begin
            if (!(w_ff == ONE_W || s_ff <= ONE_W || step_ff == '0)) begin
               if (w_ff >= s_ff) begin
                  if (mag_sum > lim) begin
                     mag_in = lim; sat_in = 1'b1;
                  end else begin
                     du_start = 1'b1; mag_in = mag_sum;
                  end
               end else begin
                  du_start = 1'b1; du_sqrt = 1'b1; du_num = s_ff; step_in = step_ff >> 1;
               end
            end
         end
         ST_DIV: if (du_done) w_in = du_res;
         ST_SQRT: if (du_done) s_in = du_res;
         ST_DONE: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1;
               out_in.log_value    = dom_ff ? '0 : (neg_ff ? -mag_ff : mag_ff);
               out_in.saturated    = sat_ff;
               out_in.domain_error = dom_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0; base_ff <= BASE_RESET;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; base_ff <= base_in;
      end
      w_ff <= w_in; s_ff <= s_in; step_ff <= step_in; mag_ff <= mag_in;
      neg_ff <= neg_in; sat_ff <= sat_in; dom_ff <= dom_in; out_ff <= out_in;
   end

   assign rsp.valid        = ov_ff;
   assign rsp.log_value    = out_ff.log_value;
   assign rsp.saturated    = out_ff.saturated;
   assign rsp.domain_error = out_ff.domain_error;
endmodule
`default_nettype wire

// ----- rtl/core/lbrs_checker.sv -----
`default_nettype none
module lbrs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [39:0] rsp_log_value,
   input wire logic rsp_saturated,
   input wire logic rsp_domain_error
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_log_value))
      else $error("result changed under stall");
   // domain error gives zero
   a_dom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_domain_error |-> rsp_log_value == '0 && !rsp_saturated)
      else $error("domain error with value");
   // saturated value sits at a limit
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
      rsp_log_value == 40'h7FFFFFFFFF || rsp_log_value == 40'h8000000000)
      else $error("saturation off limit");
endmodule

bind log_by_repeated_square_root_core lbrs_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_log_value(rsp.log_value), .rsp_saturated(rsp.saturated),
   .rsp_domain_error(rsp.domain_error));
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import lbrs_pkg::*;

   localparam int unsigned STALL_LIMIT = 16_000_000;
   localparam logic [2:0] ADDR_LOG_BASE = 3'(REG_LOG_BASE) << 2;
   localparam logic [63:0] UNIT_IN = 64'd1 << IN_FRAC_BITS;

   typedef struct {
      logic [OP_W-1:0] operand;
      bit              typed;
      rsp_type         fixed;
   } vector_type;

   logic clock;
   logic reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lbrs_req_if req_ch ();
   lbrs_rsp_if rsp_ch ();

   log_by_repeated_square_root_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the base register and results still owed by the block
   logic [OP_W-1:0] base_shadow;
   rsp_type         pending_logs[$];
   int unsigned     mismatches;
   int unsigned     logs_checked;
   int unsigned     operands_sent;
   int unsigned     bases_used;
   int unsigned     quiet_cycles;
   bit              calm;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // floor square root, one result bit at a time from the top
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // logarithm of one operand to the current base
   function automatic rsp_type predict_log(input logic [OP_W-1:0] op);
      logic [63:0] work;
      logic [63:0] scale;
      logic [63:0] step;
      logic [63:0] mag;
      logic [63:0] limit;
      logic [63:0] quo;
      logic [63:0] rem;
      bit          neg;
      bit          sat;
      rsp_type     res;
      res = '0;
      if (op == '0) begin
         res.domain_error = 1'b1;
         return res;
      end
      neg   = (64'(op) < UNIT_IN);
      work  = neg ? (64'd1 << (2 * IN_FRAC_BITS)) / 64'(op) : 64'(op);
      limit = (64'd1 << (OUT_W - 1)) - (neg ? 64'd0 : 64'd1);
      scale = 64'(base_shadow);
      step  = 64'd1 << OUT_FRAC_BITS;
      mag   = '0;
      sat   = 1'b0;
      while (work != UNIT_IN && scale > UNIT_IN && step != 0) begin
         if (work >= scale) begin
            if (mag + step > limit) begin
               mag = limit;
               sat = 1'b1;
               break;
            end
            quo  = work / scale;
            rem  = work % scale;
            work = (quo << IN_FRAC_BITS) + ((rem << IN_FRAC_BITS) / scale);
            mag  = mag + step;
         end else begin
            scale = floor_sqrt(scale << IN_FRAC_BITS);
            step  = step >> 1;
         end
      end
      res.log_value = neg ? OUT_W'(-mag) : OUT_W'(mag);
      res.saturated = sat;
      return res;
   endfunction

   // offer one operand; valid is left high for a possible back-to-back transfer
   task automatic send_operand(input logic [OP_W-1:0] op, input bit typed,
         input rsp_type fixed);
      while (!calm && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.operand <= op;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      pending_logs.push_back(typed ? fixed : predict_log(op));
      operands_sent++;
   endtask

   // lower valid and wait until every owed result has come back
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_logs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_base(input logic [OP_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_LOG_BASE;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      base_shadow = value;
      bases_used++;
   endtask

   // mix of wide, sub-unity, near-unity and zero operands, or near-unity only on request
   function automatic logic [OP_W-1:0] pick_operand(input bit near_only);
      if (near_only) begin
         return OP_W'($urandom_range(65552, 65520));
      end
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return OP_W'($urandom_range(65535, 1));
         3:       return OP_W'($urandom_range(65536 + 4096, 65536 - 4096));
         4:       return {16'hFFFF, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(input int n, input bit near_only);
      for (int i = 0; i < n; i++) begin
         calm = (i >= n / 3) && (i < n / 2);
         send_operand(pick_operand(near_only), 1'b0, '0);
      end
      calm = 1'b0;
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_logs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result log_value=%h", rsp_ch.log_value);
            end
         end else begin
            want = pending_logs.pop_front();
            logs_checked++;
            if (rsp_ch.log_value !== want.log_value || rsp_ch.saturated !== want.saturated
                  || rsp_ch.domain_error !== want.domain_error) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp log=%h sat=%b dom=%b  got log=%h sat=%b dom=%b",
                     want.log_value, want.saturated, want.domain_error,
                     rsp_ch.log_value, rsp_ch.saturated, rsp_ch.domain_error);
               end
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 23);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      vector_type table_rows[$];
      vector_type row;
      rsp_type    fixed;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.operand = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      base_shadow    = BASE_RESET;
      mismatches     = 0;
      logs_checked   = 0;
      operands_sent  = 0;
      bases_used     = 1;
      quiet_cycles   = 0;
      calm           = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under the reset base (e)
      fixed = '0; fixed.domain_error = 1'b1;
      table_rows.push_back('{32'd0, 1'b1, fixed});
      fixed = '0;
      table_rows.push_back('{32'd65536, 1'b1, fixed});
      fixed = '0; fixed.log_value = OUT_W'(1) << OUT_FRAC_BITS;
      table_rows.push_back('{32'd178145, 1'b1, fixed});
      table_rows.push_back('{32'd1, 1'b0, '0});
      table_rows.push_back('{32'hFFFF_FFFF, 1'b0, '0});
      table_rows.push_back('{32'd65535, 1'b0, '0});
      table_rows.push_back('{32'd65537, 1'b0, '0});
      table_rows.push_back('{32'd32768, 1'b0, '0});
      table_rows.push_back('{32'd131072, 1'b0, '0});
      table_rows.push_back('{32'h8000_0000, 1'b0, '0});
      table_rows.push_back('{32'h5555_5555, 1'b0, '0});
      table_rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
      table_rows.push_back('{32'd484249, 1'b0, '0});
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_operand(row.operand, row.typed, row.fixed);
      end
      drain();

      // smallest base: clipping at the positive limit, then near-unity operands
      write_base(32'd65537);
      fixed = '0; fixed.log_value = OUT_W'((64'd1 << (OUT_W - 1)) - 1); fixed.saturated = 1'b1;
      send_operand(32'hFFFF_FFFF, 1'b1, fixed);
      drain();
      random_phase(60, 1'b1);
      drain();

      write_base(32'hFFFF_FFFF);
      random_phase(220, 1'b0);
      drain();
      write_base(32'd131072);
      random_phase(220, 1'b0);
      drain();
      write_base(BASE_RESET);
      random_phase(250, 1'b0);
      drain();
      for (int p = 0; p < 5; p++) begin
         write_base(OP_W'($urandom_range(32'hFFFF_FFFF, 98304)));
         random_phase(200, 1'b0);
         drain();
      end

      repeat (200) @(posedge clock);
      $display("%0d operands sent, %0d results checked over %0d base settings",
         operands_sent, logs_checked, bases_used);
      if (mismatches == 0 && pending_logs.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_logs.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ----- log_by_repeated_square_root_core.f -----
rtl/core/lbrs_pkg.sv
rtl/core/lbrs_if.sv
rtl/core/lbrs_divsqrt.sv
rtl/core/log_by_repeated_square_root_core.sv
rtl/core/lbrs_checker.sv
sim/testbench.sv
